/* hw/rtl/fmae_pkg.sv */
// Package for the frame mean auto exposure block: payload types, constants, exposure ROM.
`timescale 1ns / 1ps
`default_nettype none
package fmae_pkg;

    localparam int SUM_W        = 40;
    localparam int TGT_W        = 14;
    localparam int IDX_W        = 9;
    localparam int ROM_SIZE     = 295;
    localparam int DEF_MAX_FRAME_PIXELS = 1048576;
    localparam int DEF_TABLE_ENTRIES    = 295;

    localparam logic [TGT_W-1:0] TARGET_RESET = TGT_W'(60);

    // 1/log2(1.03125) in Q16
    localparam logic signed [22:0] LOGB_K = 23'sd1476232;
    // 5 * 65536: step divisor applied to the doubled log ratio
    localparam logic [30:0] STEP_DIV = 31'd327680;
    localparam logic [3:0]  STEP_MAX = 4'd10;

    typedef enum logic [0:0] {
        REG_TARGET_LEVEL = 1'b0,
        REG_WIDE_PIXELS  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] pixel_value;
        logic        frame_end;
        logic [15:0] current_time;
        logic [15:0] current_gain;
    } pix_in_t;

    typedef struct packed {
        logic [10:0] new_gain;
        logic [15:0] new_time;
        logic        updated;
    } ae_out_t;

    typedef struct packed {
        logic [10:0] gain;
        logic [15:0] time_val;
    } ae_entry_t;

    localparam ae_entry_t AE_ROM [ROM_SIZE] = '{
 '{256,1},'{264,1},'{272,1},'{281,1},'{290,1},'{299,1},'{308,1},'{318,1},
 '{328,1},'{338,1},'{349,1},'{360,1},'{371,1},'{383,1},'{395,1},'{407,1},
 '{420,1},'{433,1},'{446,1},'{460,1},'{474,1},'{489,1},'{504,1},'{260,2},
 '{268,2},'{277,2},'{286,2},'{295,2},'{304,2},'{314,2},'{324,2},'{334,2},
 '{345,2},'{356,2},'{367,2},'{379,2},'{261,3},'{269,3},'{278,3},'{287,3},
 '{296,3},'{305,3},'{315,3},'{325,3},'{335,3},'{259,4},'{267,4},'{276,4},
 '{285,4},'{294,4},'{303,4},'{313,4},'{258,5},'{266,5},'{274,5},'{283,5},
 '{292,5},'{301,5},'{259,6},'{267,6},'{276,6},'{285,6},'{294,6},'{260,7},
 '{268,7},'{277,7},'{286,7},'{258,8},'{266,8},'{274,8},'{283,8},'{260,9},
 '{268,9},'{277,9},'{257,10},'{265,10},'{273,10},'{256,11},'{264,11},'{272,11},
 '{257,12},'{265,12},'{273,12},'{260,13},'{268,13},'{257,14},'{265,14},'{273,14},
 '{263,15},'{271,15},'{262,16},'{270,16},'{262,17},'{270,17},'{263,18},'{257,19},
 '{265,19},'{260,20},'{268,20},'{263,21},'{259,22},'{267,22},'{264,23},'{261,24},
 '{259,25},'{257,26},'{265,26},'{263,27},'{262,28},'{261,29},'{260,30},'{260,31},
 '{260,32},'{260,33},'{260,34},'{261,35},'{262,36},'{256,38},'{257,39},'{259,40},
 '{261,41},'{257,43},'{259,44},'{261,45},'{258,47},'{261,48},'{259,50},'{257,52},
 '{260,53},'{259,55},'{258,57},'{257,59},'{257,61},'{257,63},'{257,65},'{257,67},
 '{258,69},'{259,71},'{256,74},'{257,76},'{258,78},'{256,81},'{258,83},'{257,86},
 '{256,89},'{258,91},'{258,94},'{258,97},'{258,100},'{258,103},'{256,107},'{257,110},
 '{258,113},'{257,117},'{256,121},'{258,124},'{256,129},'{256,133},'{256,137},'{257,141},
 '{256,146},'{257,150},'{257,155},'{257,160},'{257,165},'{257,170},'{256,176},'{257,181},
 '{257,187},'{257,193},'{257,199},'{257,205},'{256,212},'{257,218},'{257,225},'{257,232},
 '{257,239},'{257,247},'{257,255},'{256,264},'{256,272},'{256,281},'{256,290},'{256,299},
 '{256,308},'{256,318},'{256,328},'{256,338},'{256,349},'{256,360},'{256,371},'{256,383},
 '{256,395},'{256,407},'{256,420},'{256,433},'{256,446},'{256,460},'{256,474},'{256,489},
 '{256,504},'{256,520},'{256,536},'{256,553},'{256,570},'{256,588},'{256,606},'{256,625},
 '{256,644},'{256,664},'{256,684},'{256,705},'{256,727},'{256,749},'{256,772},'{256,796},
 '{256,820},'{256,845},'{256,871},'{256,898},'{256,925},'{256,953},'{256,982},'{256,1012},
 '{256,1043},'{256,1075},'{256,1108},'{264,1108},'{272,1108},'{281,1108},'{290,1108},
 '{299,1108},'{308,1108},'{318,1108},'{328,1108},'{338,1108},'{349,1108},'{360,1108},
 '{371,1108},'{383,1108},'{395,1108},'{407,1108},'{420,1108},'{433,1108},'{446,1108},
 '{460,1108},'{474,1108},'{489,1108},'{504,1108},'{520,1108},'{536,1108},'{553,1108},
 '{570,1108},'{588,1108},'{606,1108},'{625,1108},'{644,1108},'{664,1108},'{684,1108},
 '{705,1108},'{727,1108},'{749,1108},'{772,1108},'{796,1108},'{820,1108},'{845,1108},
 '{871,1108},'{898,1108},'{925,1108},'{953,1108},'{982,1108},'{1012,1108},'{1043,1108},
 '{1075,1108},'{1108,1108},'{1142,1108},'{1177,1108},'{1213,1108},'{1250,1108},
 '{1288,1108},'{1327,1108},'{1367,1108},'{1409,1108},'{1452,1108},'{1496,1108},
 '{1541,1108},'{1588,1108},'{1636,1108},'{1686,1108},'{1737,1108},'{1790,1108},
 '{1844,1108},'{1900,1108},'{1957,1108},'{2016,1108}
    };

endpackage
`default_nettype wire

/* hw/rtl/frame_mean_auto_exposure.sv */
// Frame mean auto exposure controller: pixel accumulator and frame-end sequencer.
//
// Input channel (in_valid/in_stall/in_data) carries one pixel item per cycle
// while in_stall is low; ordinary pixels only update the frame sum and count.
// The item flagged frame_end starts the exposure update: a small sequencer runs
// one shared log2 unit (bit-at-a-time normalize, then 16 squaring rounds) up to
// three times, one Q16 scale multiply per log difference, and a subtract loop
// for the step. in_stall stays high while it runs, for a span set mostly by the
// normalize shifts of the log2 unit. Each frame end yields one item on
// out_valid/out_stall/out_data; frame gaps longer than the run keep full rate.
// The result sits in an output register; a stalled result holds and the next
// frame's pixels are still taken; a later frame end waits for the slot to free.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at once and
// belong in idle time. Reset clears the frame sum and count, drops any pending
// result and loads target 60, narrow pixels.
`timescale 1ns / 1ps
`default_nettype none
module frame_mean_auto_exposure #(
    parameter int MAX_FRAME_PIXELS = fmae_pkg::DEF_MAX_FRAME_PIXELS,
    parameter int TABLE_ENTRIES    = fmae_pkg::DEF_TABLE_ENTRIES
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire fmae_pkg::cfg_reg_t        cfg_index,
    input  wire logic [fmae_pkg::TGT_W-1:0] cfg_wdata,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire fmae_pkg::pix_in_t         in_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output fmae_pkg::ae_out_t              out_data
);
    import fmae_pkg::*;

    localparam int TW = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int AW = TGT_W + TW;
    localparam logic [TW-1:0]    MAX_N   = TW'(MAX_FRAME_PIXELS);
    localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic signed [28:0] X_TOP = 29'(TABLE_ENTRIES * 65536);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_E, ST_NORM, ST_SQR, ST_LOG_DONE, ST_MULK, ST_SCALE,
        ST_IDX, ST_ROM, ST_NUDGE, ST_MUL_A, ST_DEAD, ST_DIVP, ST_DIV, ST_STEP,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {PH_EXPO, PH_TGT, PH_SUM} phase_t;

    state_t state_reg;
    phase_t phase_reg;

    logic [TGT_W-1:0] target_reg;
    logic             wide_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [TW-1:0]    tally_reg;

    logic [SUM_W-1:0] s_reg;
    logic [TW-1:0]    n_reg;
    logic [15:0]      ctime_reg;
    logic [15:0]      cgain_reg;
    logic [31:0]      expo_reg;
    logic [AW-1:0]    a_reg;

    logic [SUM_W-1:0] lv_reg;
    logic [5:0]       lp_reg;
    logic [30:0]      lm_reg;
    logic [15:0]      lf_reg;
    logic [3:0]       li_reg;
    logic [21:0]      l1_reg;

    logic signed [22:0] dlog_reg;
    logic signed [45:0] prod_reg;
    logic signed [28:0] x_reg;
    logic               neg_reg;
    logic [30:0]        mag_reg;
    logic [3:0]         q_reg;
    logic [IDX_W-1:0]   idx_reg;
    ae_entry_t          rom_reg;
    ae_out_t            res_reg;
    logic               out_valid_reg;
    ae_out_t            out_data_reg;

    // combinational helpers
    logic [15:0]      px;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] sum_new;
    logic [TW-1:0]    tally_new;
    logic             acc_ok;
    logic             in_acc;
    logic [61:0]      sq;
    logic [31:0]      sq_top;
    logic [21:0]      lval;
    logic signed [45:0] prod_adj;
    logic signed [30:0] t_step;
    logic signed [29:0] x_round;
    logic [IDX_W-1:0] idx_sel;
    logic [IDX_W:0]   idx_wide;
    logic [26:0]      here;
    logic [SUM_W-1:0] diff;
    logic [TW+3:0]    nine_n;
    logic signed [IDX_W+1:0] idx_step;
    logic signed [IDX_W+1:0] gap;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        px        = wide_reg ? in_data.pixel_value : {8'd0, in_data.pixel_value[7:0]};
        acc_ok    = (tally_reg < MAX_N);
        sum_add   = {1'b0, sum_reg} + {{(SUM_W-15){1'b0}}, px};
        sum_new   = sum_reg;
        tally_new = tally_reg;
        if (acc_ok)
        begin
            sum_new   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            tally_new = tally_reg + TW'(1);
        end

        sq     = {31'd0, lm_reg} * {31'd0, lm_reg};
        sq_top = sq[61:30];
        lval   = {lp_reg, lf_reg};

        // add 65535 ahead of the shift to truncate toward zero
        prod_adj = prod_reg + (prod_reg < 0 ? 46'sd65535 : 46'sd0);
        t_step   = 31'(({{2{x_reg[28]}}, x_reg} + 31'sd32768) * 31'sd2);

        x_round  = 30'(({x_reg[28], x_reg} + 30'sd32768) >>> 16);
        if (x_reg < 0)
            idx_wide = '0;
        else if (x_reg > X_TOP)
            idx_wide = {1'b0, LAST_IX};
        else
            idx_wide = x_round[IDX_W:0];
        if (idx_wide > {1'b0, LAST_IX})
            idx_wide = {1'b0, LAST_IX};
        idx_sel = idx_wide[IDX_W-1:0];
        if (idx_sel >= IDX_W'(2))
            idx_sel = idx_sel - IDX_W'(2);

        here   = {16'd0, rom_reg.gain} * {11'd0, rom_reg.time_val};
        diff   = ({{(SUM_W-AW){1'b0}}, a_reg} > s_reg)
                 ? ({{(SUM_W-AW){1'b0}}, a_reg} - s_reg)
                 : (s_reg - {{(SUM_W-AW){1'b0}}, a_reg});
        nine_n = {n_reg, 3'd0} + {4'd0, n_reg};

        gap      = neg_reg ? -$signed({{(IDX_W-2){1'b0}}, q_reg})
                           : $signed({{(IDX_W-2){1'b0}}, q_reg});
        idx_step = $signed({2'b00, idx_reg}) + gap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_EXPO;
            target_reg    <= TARGET_RESET;
            wide_reg      <= 1'b0;
            sum_reg       <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_TARGET_LEVEL: target_reg <= cfg_wdata;
                    REG_WIDE_PIXELS:  wide_reg   <= cfg_wdata[0];
                    default:          ;
                endcase
            end

            if ((state_reg == ST_FIN) && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (in_data.frame_end)
                        begin
                            s_reg     <= wide_reg ? (sum_new >> 2) : sum_new;
                            n_reg     <= (tally_new == '0) ? TW'(1) : tally_new;
                            ctime_reg <= in_data.current_time;
                            cgain_reg <= in_data.current_gain;
                            sum_reg   <= '0;
                            tally_reg <= '0;
                            state_reg <= ST_MUL_E;
                        end
                        else
                        begin
                            sum_reg   <= sum_new;
                            tally_reg <= tally_new;
                        end
                    end
                end
                ST_MUL_E:
                begin
                    expo_reg  <= ctime_reg * cgain_reg;
                    phase_reg <= PH_EXPO;
                    lv_reg    <= {8'd0, 32'(ctime_reg) * 32'(cgain_reg)};
                    lp_reg    <= 6'(SUM_W - 1);
                    if ((ctime_reg == 16'd0) || (cgain_reg == 16'd0))
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_ROM;
                    end
                    else
                        state_reg <= ST_NORM;
                end
                ST_NORM:
                begin
                    // shift until the leading one reaches the top bit
                    if (!lv_reg[SUM_W-1] && (lp_reg != 6'd0))
                    begin
                        lv_reg <= lv_reg << 1;
                        lp_reg <= lp_reg - 6'd1;
                    end
                    else
                    begin
                        lm_reg    <= lv_reg[SUM_W-1:SUM_W-31];
                        lf_reg    <= '0;
                        li_reg    <= '0;
                        state_reg <= ST_SQR;
                    end
                end
                ST_SQR:
                begin
                    if (sq_top[31])
                    begin
                        lm_reg <= sq_top[31:1];
                        lf_reg[4'd15 - li_reg] <= 1'b1;
                    end
                    else
                        lm_reg <= sq_top[30:0];
                    li_reg <= li_reg + 4'd1;
                    if (li_reg == 4'd15)
                        state_reg <= ST_LOG_DONE;
                end
                ST_LOG_DONE:
                begin
                    case (phase_reg)
                        PH_EXPO:
                        begin
                            dlog_reg  <= $signed({1'b0, lval}) - 23'sd524288;
                            state_reg <= ST_MULK;
                        end
                        PH_TGT:
                        begin
                            l1_reg    <= lval;
                            phase_reg <= PH_SUM;
                            lv_reg    <= (s_reg == '0) ? SUM_W'(1) : s_reg;
                            lp_reg    <= 6'(SUM_W - 1);
                            state_reg <= ST_NORM;
                        end
                        default:
                        begin
                            dlog_reg  <= $signed({1'b0, l1_reg}) - $signed({1'b0, lval});
                            state_reg <= ST_MULK;
                        end
                    endcase
                end
                ST_MULK:
                begin
                    prod_reg  <= 46'(dlog_reg) * 46'(LOGB_K);
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    x_reg     <= prod_adj[44:16];
                    state_reg <= (phase_reg == PH_EXPO) ? ST_IDX : ST_DIVP;
                end
                ST_IDX:
                begin
                    idx_reg   <= idx_sel;
                    state_reg <= ST_ROM;
                end
                ST_ROM:
                begin
                    // a stepped index reads its entry here and goes straight out
                    rom_reg   <= AE_ROM[idx_reg];
                    state_reg <= (phase_reg == PH_SUM) ? ST_FIN : ST_NUDGE;
                end
                ST_NUDGE:
                begin
                    // move one entry toward the applied exposure
                    if (({5'd0, here} > expo_reg) && (idx_reg >= IDX_W'(1)))
                        idx_reg <= idx_reg - IDX_W'(1);
                    else if (({5'd0, here} < expo_reg) && (idx_reg < LAST_IX))
                        idx_reg <= idx_reg + IDX_W'(1);
                    state_reg <= ST_MUL_A;
                end
                ST_MUL_A:
                begin
                    a_reg     <= AW'(target_reg) * AW'(n_reg);
                    state_reg <= ST_DEAD;
                end
                ST_DEAD:
                begin
                    if (diff < SUM_W'(nine_n))
                    begin
                        res_reg.new_gain <= (cgain_reg > 16'd2047) ? 11'h7FF : cgain_reg[10:0];
                        res_reg.new_time <= ctime_reg;
                        res_reg.updated  <= 1'b0;
                        state_reg        <= ST_FIN;
                    end
                    else
                    begin
                        phase_reg <= PH_TGT;
                        lv_reg    <= (target_reg == '0) ? SUM_W'(n_reg) : SUM_W'(a_reg);
                        lp_reg    <= 6'(SUM_W - 1);
                        state_reg <= ST_NORM;
                    end
                end
                ST_DIVP:
                begin
                    neg_reg   <= t_step[30];
                    mag_reg   <= t_step[30] ? 31'(-t_step) : t_step;
                    q_reg     <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if ((mag_reg >= STEP_DIV) && (q_reg < STEP_MAX))
                    begin
                        mag_reg <= mag_reg - STEP_DIV;
                        q_reg   <= q_reg + 4'd1;
                    end
                    else
                        state_reg <= ST_STEP;
                end
                ST_STEP:
                begin
                    if (idx_step < 0)
                        idx_reg <= '0;
                    else if (idx_step > $signed({2'b00, LAST_IX}))
                        idx_reg <= LAST_IX;
                    else
                        idx_reg <= idx_step[IDX_W-1:0];
                    state_reg <= ST_ROM;
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        if (phase_reg == PH_SUM)
                        begin
                            out_data_reg.new_gain <= rom_reg.gain;
                            out_data_reg.new_time <= rom_reg.time_val;
                            out_data_reg.updated  <= 1'b1;
                        end
                        else
                            out_data_reg <= res_reg;
                        phase_reg <= PH_EXPO;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* tb/tb_frame_mean_auto_exposure.sv */
// Testbench for the frame mean auto exposure block: directed and random frames, self-checking.
`timescale 1ns / 1ps
module tb_frame_mean_auto_exposure;
    import fmae_pkg::*;

    localparam int  MAX_PIX    = DEF_MAX_FRAME_PIXELS;
    localparam int  TBL_N      = DEF_TABLE_ENTRIES;
    localparam longint unsigned SUM_SAT = 64'hFF_FFFF_FFFF;
    localparam longint CYCLE_LIMIT = 20000000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    cfg_reg_t          cfg_index = REG_TARGET_LEVEL;
    logic [TGT_W-1:0]  cfg_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    pix_in_t           in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b1;
    ae_out_t           out_data;

    // predictor state
    longint unsigned   frame_sum;
    int unsigned       frame_tally;
    logic [TGT_W-1:0]  tgt_level;
    logic              wide_mode;

    ae_out_t           setting_q[$];
    int                errors = 0;
    longint            cycles = 0;

    frame_mean_auto_exposure uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic longint log2_fix(longint unsigned v);
        int p;
        longint unsigned m;
        longint frac;
        p = 63;
        frac = 0;
        if (v == 0)
            v = 1;
        while (p > 0 && v[p] == 1'b0)
            p--;
        if (p > 30)
            m = v >> (p - 30);
        else
            m = v << (30 - p);
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                frac = frac | (longint'(1) << (15 - i));
            end
        end
        return longint'(p) * 65536 + frac;
    endfunction

    function automatic longint exposure_log(longint unsigned a, longint unsigned b);
        longint d;
        d = log2_fix(a) - log2_fix(b);
        return (d * 64'sd1476232) / 64'sd65536;
    endfunction

    // Advance the predictor by one pixel; return 1 with the setting on frame end.
    function automatic bit next_setting(pix_in_t it, output ae_out_t res);
        longint unsigned px, s, n, a, d, expo, here;
        longint x;
        int idx;
        px = wide_mode ? it.pixel_value : it.pixel_value[7:0];
        res = '0;
        if (frame_tally < MAX_PIX)
        begin
            frame_sum = (frame_sum + px > SUM_SAT) ? SUM_SAT : frame_sum + px;
            frame_tally++;
        end
        if (!it.frame_end)
            return 1'b0;
        s = wide_mode ? (frame_sum >> 2) : frame_sum;
        n = (frame_tally != 0) ? frame_tally : 1;
        frame_sum = 0;
        frame_tally = 0;
        expo = longint'(it.current_time) * longint'(it.current_gain);
        if (expo == 0)
            idx = 0;
        else
        begin
            x = exposure_log(expo, 256);
            if (x < 0)
                idx = 0;
            else if (x > (longint'(TBL_N) << 16))
                idx = TBL_N - 1;
            else
                idx = int'((x + 32768) >>> 16);
        end
        if (idx > TBL_N - 1)
            idx = TBL_N - 1;
        if (idx >= 2)
            idx -= 2;
        here = longint'(AE_ROM[idx].gain) * longint'(AE_ROM[idx].time_val);
        if (here > expo && idx >= 1)
            idx--;
        else if (here < expo && idx + 1 <= TBL_N - 1)
            idx++;
        a = longint'(tgt_level) * n;
        d = (a > s) ? a - s : s - a;
        if (d < 9 * n)
        begin
            res.new_gain = (it.current_gain > 2047) ? 11'd2047 : it.current_gain[10:0];
            res.new_time = it.current_time;
            res.updated  = 1'b0;
            return 1'b1;
        end
        x = exposure_log(longint'((tgt_level != 0) ? tgt_level : 1) * n, (s != 0) ? s : 1);
        x = ((x + 32768) * 2) / 64'sd327680;
        if (x > 10)
            x = 10;
        else if (x < -10)
            x = -10;
        idx += int'(x);
        if (idx < 0)
            idx = 0;
        if (idx > TBL_N - 1)
            idx = TBL_N - 1;
        res.new_gain = AE_ROM[idx].gain;
        res.new_time = AE_ROM[idx].time_val;
        res.updated  = 1'b1;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
        $display("mismatch %s: expected %0d got %0d at cycle %0d", what, want, got, cycles);
        errors++;
    endtask

    // Enter at a rising edge, leave at the edge that accepts the item.
    task automatic send_pixel(pix_in_t it);
        int gap;
        ae_out_t res;
        gap = $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
        end
        @(posedge clk);
        if (next_setting(it, res))
            setting_q.push_back(res);
    endtask

    task automatic drain_settings();
        in_valid <= 1'b0;
        while (setting_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [TGT_W-1:0] val);
        drain_settings();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_TARGET_LEVEL)
            tgt_level = val;
        else
            wide_mode = val[0];
    endtask

    // result side: stall for a drawn number of cycles, then take one item
    initial
    begin
        int w;
        ae_out_t got, want;
        @(posedge rst_n);
        forever
        begin
            w = $urandom_range(0, 15);
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            forever
            begin
                @(negedge clk);
                if (out_valid)
                    break;
            end
            got = out_data;
            @(posedge clk);
            if (setting_q.size() == 0)
            begin
                $display("unexpected item at cycle %0d", cycles);
                errors++;
            end
            else
            begin
                want = setting_q.pop_front();
                if (got.new_gain != want.new_gain)
                    report_mismatch("new_gain", want.new_gain, got.new_gain);
                if (got.new_time != want.new_time)
                    report_mismatch("new_time", want.new_time, got.new_time);
                if (got.updated != want.updated)
                    report_mismatch("updated", want.updated, got.updated);
            end
        end
    end

    function automatic pix_in_t make_pixel(logic [15:0] px, bit last, logic [15:0] t,
                                           logic [15:0] g);
        pix_in_t it;
        it.pixel_value  = px;
        it.frame_end    = last;
        it.current_time = t;
        it.current_gain = g;
        return it;
    endfunction

    task automatic test_directed();
        // extremes of exposure and gain
        send_pixel(make_pixel(16'h0000, 1'b1, 16'd0, 16'd256));
        send_pixel(make_pixel(16'hFFFF, 1'b1, 16'd100, 16'd0));
        send_pixel(make_pixel(16'h003C, 1'b1, 16'hFFFF, 16'hFFFF));
        send_pixel(make_pixel(16'hFF3A, 1'b1, 16'd40, 16'd3000));
        send_pixel(make_pixel(16'd10, 1'b0, 16'd1, 16'd1));
        send_pixel(make_pixel(16'd250, 1'b1, 16'd1, 16'd1));
        send_pixel(make_pixel(16'd255, 1'b0, 16'd1108, 16'd2016));
        send_pixel(make_pixel(16'd255, 1'b1, 16'd1108, 16'd2016));
        send_pixel(make_pixel(16'd0, 1'b1, 16'd1, 16'd256));
        send_pixel(make_pixel(16'd64, 1'b1, 16'd5, 16'd1));
        write_reg(REG_TARGET_LEVEL, '0);
        send_pixel(make_pixel(16'd0, 1'b1, 16'd300, 16'd256));
        send_pixel(make_pixel(16'd200, 1'b1, 16'd300, 16'd256));
        write_reg(REG_TARGET_LEVEL, 14'd16383);
        send_pixel(make_pixel(16'd255, 1'b1, 16'd20, 16'd300));
        write_reg(REG_WIDE_PIXELS, 1'b1);
        send_pixel(make_pixel(16'hFFFF, 1'b0, 16'd20, 16'd300));
        send_pixel(make_pixel(16'hFFFF, 1'b1, 16'd20, 16'd300));
        send_pixel(make_pixel(16'd3, 1'b1, 16'd20, 16'd300));
        send_pixel(make_pixel(16'd0, 1'b1, 16'd1, 16'd256));
        write_reg(REG_TARGET_LEVEL, 14'd1000);
        send_pixel(make_pixel(16'd4000, 1'b1, 16'd500, 16'd256));
        send_pixel(make_pixel(16'd4040, 1'b1, 16'd500, 16'd2500));
    endtask

    task automatic test_random_frames(int count);
        int sent, len, base, noise;
        logic [15:0] px, t, g;
        sent = 0;
        while (sent < count)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
            base = wide_mode ? 4 * int'(tgt_level) : int'(tgt_level);
            case ($urandom_range(0, 3))
                0: noise = 4;
                1: noise = 30;
                2: noise = base + 1;
                default: noise = 0;
            endcase
            if ($urandom_range(0, 1))
            begin
                t = 16'($urandom_range(1, 1108));
                g = 16'($urandom_range(256, 2016));
            end
            else
            begin
                t = 16'($urandom_range(0, 65535));
                g = 16'($urandom_range(0, 65535));
            end
            for (int i = 0; i < len; i++)
            begin
                if (noise == 0)
                    px = 16'($urandom_range(0, 65535));
                else
                begin
                    base = base + $urandom_range(0, 2 * noise) - noise;
                    if (base < 0)
                        base = 0;
                    px = (base > 65535) ? 16'hFFFF : base[15:0];
                    if (!wide_mode)
                        px[15:8] = 8'($urandom_range(0, 255));
                end
                send_pixel(make_pixel(px, i == len - 1, t, g));
                sent++;
            end
        end
    endtask

    task automatic test_long_frame();
        for (int i = 0; i < 80; i++)
            send_pixel(make_pixel(16'hFFFF, i == 79, 16'd100, 16'd256));
    endtask

    initial
    begin
        frame_sum   = 0;
        frame_tally = 0;
        tgt_level   = TARGET_RESET;
        wide_mode   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        write_reg(REG_WIDE_PIXELS, 1'b0);
        write_reg(REG_TARGET_LEVEL, 14'd60);
        test_random_frames(250);
        write_reg(REG_TARGET_LEVEL, 14'd200);
        test_random_frames(200);
        write_reg(REG_WIDE_PIXELS, 1'b1);
        write_reg(REG_TARGET_LEVEL, 14'd5000);
        test_random_frames(250);
        write_reg(REG_TARGET_LEVEL, 14'd16383);
        test_random_frames(150);
        write_reg(REG_TARGET_LEVEL, 14'($urandom_range(0, 16383)));
        test_random_frames(150);
        write_reg(REG_WIDE_PIXELS, 1'b0);
        write_reg(REG_TARGET_LEVEL, 14'd255);
        test_long_frame();
        drain_settings();
        repeat (300) @(posedge clk);
        if (errors == 0 && setting_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/fmae_pkg.sv
hw/rtl/frame_mean_auto_exposure.sv
tb/tb_frame_mean_auto_exposure.sv
